// ----- rtl/ilpo_pkg.sv -----
// shared constants and types of the incremental log-product objective block
package ilpo_pkg;

  localparam int NUM_VARIABLES_DEF = 1024;
  localparam int NUM_S_GROUPS_DEF  = 256;
  localparam int NUM_T_GROUPS_DEF  = 256;

  localparam int OPCODE_W = 3;
  localparam int INDEX_W  = 10;
  localparam int LEVEL_W  = 16;
  localparam int WORD_W   = 32;
  localparam int GROUP_W  = 8;
  localparam int WIDE_W   = 64;

  // variable row: value, scale, offset, s group, t group
  localparam int ROW_W = 3 * WORD_W + 2 * GROUP_W;

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  // about 1 / (16 ln2) in q.30, the quotient is corrected afterwards
  localparam logic [26:0] EXP_RECIP = 27'd96817625;
  localparam int LOG_STEPS = 28;
  localparam int EXP_TERMS = 13;

  // floor(2^31 / k) + 1, quotient may come out one high
  localparam logic [31:0] RECIP_K [16] = '{
    32'd0,
    32'((64'd1 << 31) / 64'd1 + 64'd1),
    32'((64'd1 << 31) / 64'd2 + 64'd1),
    32'((64'd1 << 31) / 64'd3 + 64'd1),
    32'((64'd1 << 31) / 64'd4 + 64'd1),
    32'((64'd1 << 31) / 64'd5 + 64'd1),
    32'((64'd1 << 31) / 64'd6 + 64'd1),
    32'((64'd1 << 31) / 64'd7 + 64'd1),
    32'((64'd1 << 31) / 64'd8 + 64'd1),
    32'((64'd1 << 31) / 64'd9 + 64'd1),
    32'((64'd1 << 31) / 64'd10 + 64'd1),
    32'((64'd1 << 31) / 64'd11 + 64'd1),
    32'((64'd1 << 31) / 64'd12 + 64'd1),
    32'((64'd1 << 31) / 64'd13 + 64'd1),
    32'd0,
    32'd0
  };

  typedef enum logic [OPCODE_W-1:0] {
    OP_UPDATE       = 3'd0,
    OP_LOAD_VAR     = 3'd1,
    OP_LOAD_WEIGHT  = 3'd2,
    OP_LOAD_LOGPROD = 3'd3,
    OP_SET_TOTAL    = 3'd4
  } opcode_t;

endpackage

// ----- rtl/ilpo_if.sv -----
// item channels of the incremental log-product objective block
interface ilpo_in_if;
  import ilpo_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic [INDEX_W-1:0]        entry_index;
  logic [LEVEL_W-1:0]        level;
  logic signed [WORD_W-1:0]  coef_value;
  logic signed [WORD_W-1:0]  offset_value;
  logic [WORD_W-1:0]         start_value;
  logic [GROUP_W-1:0]        group_s;
  logic [GROUP_W-1:0]        group_t;
  logic signed [WIDE_W-1:0]  wide_value;
  modport source (output valid, opcode, entry_index, level, coef_value, offset_value,
                  start_value, group_s, group_t, wide_value, input ready);
  modport sink (input valid, opcode, entry_index, level, coef_value, offset_value,
                start_value, group_s, group_t, wide_value, output ready);
endinterface

interface ilpo_out_if;
  import ilpo_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [WIDE_W-1:0]  running_value;
  logic                      domain_error;
  modport source (output valid, running_value, domain_error, input ready);
  modport sink (input valid, running_value, domain_error, output ready);
endinterface

// ----- rtl/ilpo_ram.sv -----
// generic single-port-write ram with registered read
module ilpo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/ilpo_mul.sv -----
// shared signed multiplier with registered product
module ilpo_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// ----- rtl/incremental_log_product_objective.sv -----
// Incremental log-product objective: load items fill the variable, weight and
// log-product tables or set the running value and give no result. In an update
// item every product goes through one shared 33x33 multiplier with a registered
// output: the 2 x 28 log squarings and the 2 x 13 Taylor terms, fewer terms when
// an exponential saturates. Each value is normalised one leading zero at a time.
// The block takes no item while an update is in work; a finished result waits in
// the output register while the next item is taken.
module incremental_log_product_objective #(
  parameter int NUM_VARIABLES = ilpo_pkg::NUM_VARIABLES_DEF,
  parameter int NUM_S_GROUPS  = ilpo_pkg::NUM_S_GROUPS_DEF,
  parameter int NUM_T_GROUPS  = ilpo_pkg::NUM_T_GROUPS_DEF
) (
  input logic        clk,
  input logic        rst,
  ilpo_in_if.sink    in_ch,
  ilpo_out_if.source out_ch
);
  import ilpo_pkg::*;

  localparam int VAW = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
  localparam int SAW = (NUM_S_GROUPS > 1) ? $clog2(NUM_S_GROUPS) : 1;
  localparam int TAW = (NUM_T_GROUPS > 1) ? $clog2(NUM_T_GROUPS) : 1;

  typedef enum logic [20:0] {
    S_IDLE   = 21'd1 << 0,
    S_VAR    = 21'd1 << 1,
    S_NEWX   = 21'd1 << 2,
    S_LNORM  = 21'd1 << 3,
    S_LSQ    = 21'd1 << 4,
    S_LACC   = 21'd1 << 5,
    S_LK     = 21'd1 << 6,
    S_LF     = 21'd1 << 7,
    S_LR     = 21'd1 << 8,
    S_WMUL   = 21'd1 << 9,
    S_WRND   = 21'd1 << 10,
    S_EN     = 21'd1 << 11,
    S_EQ     = 21'd1 << 12,
    S_ERM    = 21'd1 << 13,
    S_ECOR   = 21'd1 << 14,
    S_ET1    = 21'd1 << 15,
    S_ET2    = 21'd1 << 16,
    S_ET3    = 21'd1 << 17,
    S_ET4    = 21'd1 << 18,
    S_ESC    = 21'd1 << 19,
    S_FINISH = 21'd1 << 20
  } state_t;

  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                   input logic [5:0] s);
    logic [63:0] mag;
    logic [63:0] half;
    mag  = v[63] ? 64'(-v) : 64'(v);
    half = 64'd1 << (s - 6'd1);
    mag  = (mag + half) >> s;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  state_t state;

  logic [VAW-1:0]     vidx;
  logic [LEVEL_W-1:0] lvl;
  logic [31:0]        oldx, newx;
  logic signed [31:0] scl, ofs, w, lpold, lpnew;
  logic [7:0]         gs, gt;
  logic [31:0]        lx;
  logic [4:0]         shcnt, sqcnt;
  logic [30:0]        m;
  logic [27:0]        frac;
  logic signed [35:0] hi;
  logic signed [31:0] ln_new, d, earg;
  logic               ln_sel, ex_sel;
  logic signed [11:0] n;
  logic signed [43:0] r;
  logic [30:0]        term, q;
  logic [31:0]        sum;
  logic [29:0]        tq;
  logic [3:0]         k;
  logic [63:0]        enew;
  logic signed [63:0] total;
  logic               err;

  logic               ov, oerr;
  logic signed [63:0] oval;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic               var_we, wt_we, lp_we, accept, fin;
  logic [VAW-1:0]     var_waddr;
  logic [ROW_W-1:0]   var_wdata, var_rd;
  logic [SAW-1:0]     wt_waddr;
  logic [TAW-1:0]     lp_waddr;
  logic [31:0]        lp_wdata, wt_rd, lp_rd;

  logic [31:0]        rd_val, rd_scl, rd_ofs;
  logic [7:0]         rd_gs, rd_gt;
  logic signed [5:0]  pm16;
  logic signed [11:0] nest;
  logic signed [49:0] nxs;
  logic signed [63:0] l2v, lnres64, ld64;
  logic signed [31:0] lnres, ldv, lpn;
  logic [31:0]        sq;
  logic [30:0]        qf;
  logic signed [11:0] sv;
  logic [5:0]         sh;
  logic [63:0]        eval;
  logic signed [63:0] ed;
  logic signed [64:0] diff;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = ov;
  assign out_ch.running_value = oval;
  assign out_ch.domain_error = oerr;

  assign {rd_val, rd_scl, rd_ofs, rd_gs, rd_gt} = var_rd;
  assign fin = (state == S_ESC) && ex_sel;

  // table writes: loads from the idle state, write-back at the end of an update
  always_comb begin
    var_we = accept && (opcode_t'(in_ch.opcode) == OP_LOAD_VAR)
             && (int'(in_ch.entry_index) < NUM_VARIABLES);
    wt_we  = accept && (opcode_t'(in_ch.opcode) == OP_LOAD_WEIGHT)
             && (int'(in_ch.entry_index) < NUM_S_GROUPS);
    lp_we  = accept && (opcode_t'(in_ch.opcode) == OP_LOAD_LOGPROD)
             && (int'(in_ch.entry_index) < NUM_T_GROUPS);
    var_waddr = VAW'(in_ch.entry_index);
    var_wdata = {in_ch.start_value, in_ch.coef_value, in_ch.offset_value,
                 in_ch.group_s, in_ch.group_t};
    wt_waddr  = SAW'(in_ch.entry_index);
    lp_waddr  = TAW'(in_ch.entry_index);
    lp_wdata  = in_ch.coef_value;
    if (fin) begin
      var_we    = 1'b1;
      var_waddr = vidx;
      var_wdata = {newx, scl, ofs, gs, gt};
      lp_we     = 1'b1;
      lp_waddr  = TAW'(gt);
      lp_wdata  = lpnew;
    end
  end

  ilpo_ram #(.WIDTH(ROW_W), .DEPTH(NUM_VARIABLES)) u_var_ram (
    .clk(clk), .we(var_we), .waddr(var_waddr), .wdata(var_wdata),
    .raddr(VAW'(in_ch.entry_index)), .rdata(var_rd)
  );

  ilpo_ram #(.WIDTH(WORD_W), .DEPTH(NUM_S_GROUPS)) u_wt_ram (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(in_ch.coef_value),
    .raddr(SAW'(rd_gs)), .rdata(wt_rd)
  );

  ilpo_ram #(.WIDTH(WORD_W), .DEPTH(NUM_T_GROUPS)) u_lp_ram (
    .clk(clk), .we(lp_we), .waddr(lp_waddr), .wdata(lp_wdata),
    .raddr(TAW'(rd_gt)), .rdata(lp_rd)
  );

  ilpo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  // datapath values taken from the registered product and the working registers
  always_comb begin
    pm16    = 6'sd15 - $signed({1'b0, shcnt});
    nest    = prod[61:50];
    nxs     = prod[49:0] + 50'(ofs);
    sq      = prod[61:30];
    l2v     = (64'(hi) <<< 28) + prod[63:0];
    lnres64 = shr_round(l2v, 6'd34);
    lnres   = lnres64[31:0];
    ld64    = shr_round(prod[63:0], 6'd16);
    ldv     = sat32(ld64);
    lpn     = sat32(64'(lpold) + 64'(ldv));
    qf      = ($unsigned(prod) > 66'(tq)) ? q - 31'd1 : q;
    sv      = n + 12'sd2;
    sh      = sv[11] ? 6'(-sv) : sv[5:0];
    if (n >= 12'sd31) begin
      eval = 64'h7fffffffffffffff;
    end else if (n < -12'sd45) begin
      eval = 64'd0;
    end else if (!sv[11]) begin
      eval = {32'd0, sum} << sh;
    end else begin
      eval = ({32'd0, sum} + (64'd1 << (sh - 6'd1))) >> sh;
    end
    ed   = $signed(enew) - $signed(eval);
    diff = 65'(total) - 65'(ed);
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_VAR: begin
        mul_a = 33'($signed(rd_scl));
        mul_b = $signed({17'd0, lvl});
      end
      S_LSQ: begin
        mul_a = $signed({2'd0, m});
        mul_b = $signed({2'd0, m});
      end
      S_LK: begin
        mul_a = 33'(pm16);
        mul_b = $signed({3'd0, LN2_Q30});
      end
      S_LF: begin
        mul_a = $signed({5'd0, frac});
        mul_b = $signed({3'd0, LN2_Q30});
      end
      S_WMUL: begin
        mul_a = 33'(w);
        mul_b = 33'(d);
      end
      S_EN: begin
        mul_a = 33'(earg);
        mul_b = $signed({6'd0, EXP_RECIP});
      end
      S_EQ: begin
        mul_a = 33'(nest);
        mul_b = $signed({3'd0, LN2_Q30});
      end
      S_ET1: begin
        mul_a = $signed({2'd0, term});
        mul_b = $signed({3'd0, r[29:0]});
      end
      S_ET2: begin
        mul_a = $signed({3'd0, prod[59:30]});
        mul_b = $signed({1'b0, RECIP_K[k]});
      end
      S_ET3: begin
        mul_a = $signed({2'd0, prod[61:31]});
        mul_b = $signed({29'd0, k});
      end
      S_IDLE, S_NEWX, S_LNORM, S_LACC, S_LR, S_WRND, S_ERM, S_ECOR, S_ET4,
      S_ESC, S_FINISH: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
      total <= '0;
    end else begin
      if (ov && out_ch.ready && (state != S_FINISH)) begin
        ov <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            vidx <= VAW'(in_ch.entry_index);
            lvl  <= in_ch.level;
            if (opcode_t'(in_ch.opcode) == OP_UPDATE) begin
              if (int'(in_ch.entry_index) < NUM_VARIABLES) begin
                state <= S_VAR;
              end else begin
                err   <= 1'b1;
                state <= S_FINISH;
              end
            end else if (opcode_t'(in_ch.opcode) == OP_SET_TOTAL) begin
              total <= in_ch.wide_value;
            end
          end
        end
        S_VAR: begin
          oldx <= rd_val;
          scl  <= rd_scl;
          ofs  <= rd_ofs;
          gs   <= rd_gs;
          gt   <= rd_gt;
          if (int'(rd_gs) >= NUM_S_GROUPS || int'(rd_gt) >= NUM_T_GROUPS) begin
            err   <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_NEWX;
          end
        end
        S_NEWX: begin
          w     <= wt_rd;
          lpold <= lp_rd;
          if (oldx == 32'd0 || nxs <= 50'sd0) begin
            err   <= 1'b1;
            state <= S_FINISH;
          end else begin
            newx   <= (nxs > 50'sh0ffffffff) ? 32'hffffffff : nxs[31:0];
            lx     <= (nxs > 50'sh0ffffffff) ? 32'hffffffff : nxs[31:0];
            shcnt  <= '0;
            ln_sel <= 1'b0;
            state  <= S_LNORM;
          end
        end
        S_LNORM: begin
          if (lx[31]) begin
            m     <= lx[31:1];
            frac  <= '0;
            sqcnt <= '0;
            state <= S_LSQ;
          end else begin
            lx    <= lx << 1;
            shcnt <= shcnt + 5'd1;
          end
        end
        S_LSQ: begin
          state <= S_LACC;
        end
        S_LACC: begin
          if (sq[31]) begin
            m    <= sq[31:1];
            frac <= {frac[26:0], 1'b1};
          end else begin
            m    <= sq[30:0];
            frac <= {frac[26:0], 1'b0};
          end
          if (int'(sqcnt) == LOG_STEPS - 1) begin
            state <= S_LK;
          end else begin
            sqcnt <= sqcnt + 5'd1;
            state <= S_LSQ;
          end
        end
        S_LK: begin
          state <= S_LF;
        end
        S_LF: begin
          hi    <= prod[35:0];
          state <= S_LR;
        end
        S_LR: begin
          if (!ln_sel) begin
            ln_new <= lnres;
            lx     <= oldx;
            shcnt  <= '0;
            ln_sel <= 1'b1;
            state  <= S_LNORM;
          end else begin
            d     <= ln_new - lnres;
            state <= S_WMUL;
          end
        end
        S_WMUL: begin
          state <= S_WRND;
        end
        S_WRND: begin
          lpnew  <= lpn;
          earg   <= lpn;
          ex_sel <= 1'b0;
          state  <= S_EN;
        end
        S_EN: begin
          state <= S_EQ;
        end
        S_EQ: begin
          n     <= nest;
          state <= S_ERM;
        end
        S_ERM: begin
          r     <= (44'(earg) <<< 6) - prod[43:0];
          state <= S_ECOR;
        end
        S_ECOR: begin
          if (r[43]) begin
            n <= n - 12'sd1;
            r <= r + 44'(LN2_Q30);
          end else if (r >= $signed({14'd0, LN2_Q30})) begin
            n <= n + 12'sd1;
            r <= r - 44'(LN2_Q30);
          end else if (n >= 12'sd31 || n < -12'sd45) begin
            state <= S_ESC;
          end else begin
            term  <= 31'd1 << 30;
            sum   <= 32'd1 << 30;
            k     <= 4'd1;
            state <= S_ET1;
          end
        end
        S_ET1: begin
          state <= S_ET2;
        end
        S_ET2: begin
          tq    <= prod[59:30];
          state <= S_ET3;
        end
        S_ET3: begin
          q     <= prod[61:31];
          state <= S_ET4;
        end
        S_ET4: begin
          term <= qf;
          sum  <= sum + {1'b0, qf};
          if (int'(k) == EXP_TERMS) begin
            state <= S_ESC;
          end else begin
            k     <= k + 4'd1;
            state <= S_ET1;
          end
        end
        S_ESC: begin
          if (!ex_sel) begin
            enew   <= eval;
            earg   <= lpold;
            ex_sel <= 1'b1;
            state  <= S_EN;
          end else begin
            if (diff[64] != diff[63]) begin
              total <= diff[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
            end else begin
              total <= diff[63:0];
            end
            err   <= 1'b0;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!ov || out_ch.ready) begin
            ov    <= 1'b1;
            oval  <= total;
            oerr  <= err;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
